[rtl/tf256_pkg.sv]
// ---------------------------------------------------------------------------
// tf256_pkg
// Shared types, constants and helpers for the Threefish-256 encrypt pipeline.
// ---------------------------------------------------------------------------
package tf256_pkg;

    localparam int ROUND_COUNT = 72;
    localparam int WORD_W      = 64;

    // Key schedule parity word
    localparam logic [WORD_W-1:0] PARITY_CONST = 64'h1BD1_1BDA_A9FC_1A22;

    typedef logic [WORD_W-1:0] word_t;

    // Everything that rides down the pipeline with one block
    typedef struct packed {
        word_t [3:0] w;   // block words
        word_t [4:0] ks;  // extended key
        word_t [2:0] ts;  // extended tweak
        word_t [3:0] sk;  // next subkey, precomputed one stage ahead
    } tf256_state_t;

    // Rotation constants, indexed by round mod 8 and MIX half
    function automatic logic [5:0] rot_amt(input logic [2:0] sel, input logic half);
        logic [5:0] amt;
        case (sel)
            3'd0:    amt = half ? 6'd16 : 6'd14;
            3'd1:    amt = half ? 6'd57 : 6'd52;
            3'd2:    amt = half ? 6'd40 : 6'd23;
            3'd3:    amt = half ? 6'd37 : 6'd5;
            3'd4:    amt = half ? 6'd33 : 6'd25;
            3'd5:    amt = half ? 6'd12 : 6'd46;
            3'd6:    amt = half ? 6'd22 : 6'd58;
            3'd7:    amt = 6'd32;
            default: amt = 6'd0;
        endcase
        return amt;
    endfunction

    function automatic word_t rotl64(input word_t v, input logic [5:0] amt);
        logic [6:0] rev;
        rev = 7'd64 - {1'b0, amt};
        return (v << amt) | (v >> rev);
    endfunction

endpackage

[rtl/tf256_inject.sv]
// ---------------------------------------------------------------------------
// tf256_inject
// Pipeline stage that adds the precomputed subkey to the block words.
// ---------------------------------------------------------------------------
module tf256_inject (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_vld,
    input  tf256_pkg::tf256_state_t in_state,
    output logic                    out_vld,
    output tf256_pkg::tf256_state_t out_state
);
    import tf256_pkg::*;

    logic         vld_reg;
    tf256_state_t state_reg;
    tf256_state_t state_next;

    always_comb
    begin
        state_next = in_state;
        for (int i = 0; i < 4; i++)
        begin
            state_next.w[i] = in_state.w[i] + in_state.sk[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign out_vld   = vld_reg;
    assign out_state = state_reg;

endmodule

[rtl/tf256_round.sv]
// ---------------------------------------------------------------------------
// tf256_round
// Pipeline stage for one MIX round plus word permutation; optionally
// precomputes the subkey used by the following injection stage.
// ---------------------------------------------------------------------------
module tf256_round #(
    parameter int ROT_SEL = 0,
    parameter bit PRE_SK  = 1'b0,
    parameter int SK_IDX  = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_vld,
    input  tf256_pkg::tf256_state_t in_state,
    output logic                    out_vld,
    output tf256_pkg::tf256_state_t out_state
);
    import tf256_pkg::*;

    localparam logic [5:0] ROT_A = rot_amt(3'(ROT_SEL), 1'b0);
    localparam logic [5:0] ROT_B = rot_amt(3'(ROT_SEL), 1'b1);
    localparam int K0 = SK_IDX % 5;
    localparam int K1 = (SK_IDX + 1) % 5;
    localparam int K2 = (SK_IDX + 2) % 5;
    localparam int K3 = (SK_IDX + 3) % 5;
    localparam int T0 = SK_IDX % 3;
    localparam int T1 = (SK_IDX + 1) % 3;

    logic         vld_reg;
    tf256_state_t state_reg;
    tf256_state_t state_next;
    word_t        x0, x1, x2, x3;
    word_t [3:0]  sk_next;

    always_comb
    begin
        x0 = in_state.w[0] + in_state.w[1];
        x1 = rotl64(in_state.w[1], ROT_A) ^ x0;
        x2 = in_state.w[2] + in_state.w[3];
        x3 = rotl64(in_state.w[3], ROT_B) ^ x2;
    end

    generate
        if (PRE_SK)
        begin : g_sk
            always_comb
            begin
                sk_next[0] = in_state.ks[K0];
                sk_next[1] = in_state.ks[K1] + in_state.ts[T0];
                sk_next[2] = in_state.ks[K2] + in_state.ts[T1];
                sk_next[3] = in_state.ks[K3] + WORD_W'(SK_IDX);
            end
        end
        else
        begin : g_no_sk
            assign sk_next = in_state.sk;
        end
    endgenerate

    always_comb
    begin
        state_next      = in_state;
        // words 1 and 3 swap after each round
        state_next.w[0] = x0;
        state_next.w[1] = x3;
        state_next.w[2] = x2;
        state_next.w[3] = x1;
        state_next.sk   = sk_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign out_vld   = vld_reg;
    assign out_state = state_reg;

endmodule

[rtl/threefish256_block_encrypt.sv]
// ---------------------------------------------------------------------------
// threefish256_block_encrypt
// Fully unrolled Threefish-256 encryption pipeline, one block per cycle unless the output stalls.
// ---------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------
//  in      | in_valid / in_stall    | plain_w0..3, key_w0..3, tweak_w0..1
//  out     | out_valid / out_stall  | cipher_w0..3
//
//  Throughput one block per cycle while the output is not stalled; stages:
//  a key-prep stage, one stage per round, one per subkey injection.
//  Reset clears the stage valid bits only.
//  A stalled result at the output freezes every stage; in_stall follows.
// ---------------------------------------------------------------------------
module threefish256_block_encrypt #(
    parameter int ROUND_COUNT = tf256_pkg::ROUND_COUNT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [63:0]            plain_w0,
    input  logic [63:0]            plain_w1,
    input  logic [63:0]            plain_w2,
    input  logic [63:0]            plain_w3,
    input  logic [63:0]            key_w0,
    input  logic [63:0]            key_w1,
    input  logic [63:0]            key_w2,
    input  logic [63:0]            key_w3,
    input  logic [63:0]            tweak_w0,
    input  logic [63:0]            tweak_w1,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [63:0]            cipher_w0,
    output logic [63:0]            cipher_w1,
    output logic [63:0]            cipher_w2,
    output logic [63:0]            cipher_w3
);
    import tf256_pkg::*;

    localparam int GROUPS  = ROUND_COUNT / 4;
    localparam int LAST    = 5 * GROUPS + 1;

    logic         en;
    logic         vld   [0:LAST];
    tf256_state_t stage [0:LAST];

    logic         vld0_reg;
    tf256_state_t prep_reg;
    tf256_state_t prep_next;

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // key schedule extension and first subkey
    always_comb
    begin
        prep_next.w[0]  = plain_w0;
        prep_next.w[1]  = plain_w1;
        prep_next.w[2]  = plain_w2;
        prep_next.w[3]  = plain_w3;
        prep_next.ks[0] = key_w0;
        prep_next.ks[1] = key_w1;
        prep_next.ks[2] = key_w2;
        prep_next.ks[3] = key_w3;
        prep_next.ks[4] = PARITY_CONST ^ key_w0 ^ key_w1 ^ key_w2 ^ key_w3;
        prep_next.ts[0] = tweak_w0;
        prep_next.ts[1] = tweak_w1;
        prep_next.ts[2] = tweak_w0 ^ tweak_w1;
        prep_next.sk[0] = key_w0;
        prep_next.sk[1] = key_w1 + tweak_w0;
        prep_next.sk[2] = key_w2 + tweak_w1;
        prep_next.sk[3] = key_w3;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg <= prep_next;
        end
    end

    assign vld[0]   = vld0_reg;
    assign stage[0] = prep_reg;

    generate
        for (genvar g = 0; g < GROUPS; g++)
        begin : g_grp
            tf256_inject u_inject (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_vld    (vld[5*g]),
                .in_state  (stage[5*g]),
                .out_vld   (vld[5*g+1]),
                .out_state (stage[5*g+1])
            );
            for (genvar r = 0; r < 4; r++)
            begin : g_rnd
                tf256_round #(
                    .ROT_SEL ((4*g + r) % 8),
                    .PRE_SK  (r == 3),
                    .SK_IDX  (g + 1)
                ) u_round (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .en        (en),
                    .in_vld    (vld[5*g+1+r]),
                    .in_state  (stage[5*g+1+r]),
                    .out_vld   (vld[5*g+2+r]),
                    .out_state (stage[5*g+2+r])
                );
            end
        end
    endgenerate

    // final subkey injection doubles as the output register
    tf256_inject u_inject_last (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (vld[LAST-1]),
        .in_state  (stage[LAST-1]),
        .out_vld   (vld[LAST]),
        .out_state (stage[LAST])
    );

    assign out_valid = vld[LAST];
    assign cipher_w0 = stage[LAST].w[0];
    assign cipher_w1 = stage[LAST].w[1];
    assign cipher_w2 = stage[LAST].w[2];
    assign cipher_w3 = stage[LAST].w[3];

    a_freeze_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while output stalled");

    a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld[0])
        else $error("accepted transaction missing from first stage");

    a_bubble_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_valid && !in_stall) |=> !vld[0])
        else $error("first stage valid without a transaction");

endmodule
